>>> rtl/pms_pkg.sv
package pms_pkg;

    localparam int ID_W    = 2;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/pms_if.sv
interface pms_req_if import pms_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [ID_W-1:0]          stack_id;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output func, output stack_id, output push_value,
                    input ready);
    modport sink   (input valid, input func, input stack_id, input push_value,
                    output ready);
endinterface

interface pms_rsp_if import pms_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] pop_data;
    logic [STAT_W-1:0]        status;

    modport source (output valid, output pop_data, output status, input ready);
    modport sink   (input valid, input pop_data, input status, output ready);
endinterface

>>> rtl/pms_ctrl.sv
module pms_ctrl import pms_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

>>> rtl/pms_dp.sv
module pms_dp import pms_pkg::*; #(
    parameter int STACK_COUNT = 2,
    parameter int SEG_DEPTH   = 8,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic                     i_func,
    input  logic [ID_W-1:0]          i_stack_id,
    input  logic signed [WORD_W-1:0] i_push_value,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [WORD_W-1:0] o_pop_data,
    output logic [STAT_W-1:0]        o_status
);

    localparam int STORE_DEPTH = STACK_COUNT * SEG_DEPTH;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(SEG_DEPTH + 1);
    localparam int SID_W       = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;

    logic                     r_func;
    logic [ID_W-1:0]          r_sid;
    logic [WORD_W-1:0]        r_val;
    logic [CNT_W-1:0]         r_count [0:STACK_COUNT-1];
    logic [DATA_WIDTH-1:0]    r_mem   [0:STORE_DEPTH-1];
    logic [DATA_WIDTH-1:0]    r_rd_data;
    logic                     r_pop_ok;
    t_status                  r_status;
    logic                     r_out_valid;
    logic [WORD_W-1:0]        r_out_data;
    t_status                  r_out_status;

    logic                     sid_valid;
    logic [SID_W-1:0]         idx;
    logic [CNT_W-1:0]         cur_cnt;
    logic [CNT_W-1:0]         slot;
    logic [ADDR_W-1:0]        addr;
    t_status                  st;
    logic                     do_push;
    logic                     do_pop;
    logic [DATA_WIDTH-1:0]    wr_word;
    logic [WORD_W-1:0]        rd_wide;

    assign sid_valid = ({1'b0, r_sid} < (ID_W + 1)'(STACK_COUNT));
    assign idx       = r_sid[SID_W-1:0];
    assign cur_cnt   = r_count[idx];
    assign slot      = (r_func == FUNC_POP) ? (cur_cnt - 1'b1) : cur_cnt;
    assign addr      = ADDR_W'(idx) * ADDR_W'(SEG_DEPTH) + ADDR_W'(slot);

    always_comb begin
        st = ST_OK;
        if (!sid_valid) begin
            st = ST_INVALID;
        end else if (r_func == FUNC_PUSH && cur_cnt == CNT_W'(SEG_DEPTH)) begin
            st = ST_OVERFLOW;
        end else if (r_func == FUNC_POP && cur_cnt == '0) begin
            st = ST_UNDERFLOW;
        end
    end

    assign do_push = i_cmd.exec && (st == ST_OK) && (r_func == FUNC_PUSH);
    assign do_pop  = i_cmd.exec && (st == ST_OK) && (r_func == FUNC_POP);

    // store the low bits, zero above the 32-bit input
    always_comb begin
        for (int j = 0; j < DATA_WIDTH; j++) begin
            wr_word[j] = (j < WORD_W) ? r_val[(j < WORD_W) ? j : WORD_W - 1] : 1'b0;
        end
    end

    // sign-extend from the stored width
    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            rd_wide[i] = r_rd_data[(i < DATA_WIDTH) ? i : DATA_WIDTH - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_sid  <= i_stack_id;
            r_val  <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status <= st;
            r_pop_ok <= do_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[addr] <= wr_word;
        end
        if (do_pop) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STACK_COUNT; k++) begin
                r_count[k] <= '0;
            end
        end else if (do_push) begin
            r_count[idx] <= cur_cnt + 1'b1;
        end else if (do_pop) begin
            r_count[idx] <= cur_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_data   <= r_pop_ok ? rd_wide : '0;
            r_out_status <= r_status;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_pop_data      = r_out_data;
    assign o_status        = r_out_status;

endmodule

>>> rtl/partitioned_multi_stack.sv
// Several LIFO stacks in one shared memory, one fixed segment of SEG_DEPTH
// words per stack (STACK_COUNT stacks, DATA_WIDTH bits per stored word).
// Request channel i_req: func (0 push, 1 pop), stack_id, push_value.
// Response channel o_rsp: pop_data and status (0 ok, 1 invalid stack,
// 2 overflow, 3 underflow); every request gives exactly one response.
// pop_data is the popped word sign-extended from DATA_WIDTH bits, else 0.
// Timing: one item at a time through the sequencer. The request is taken
// in the idle state, the stack count and the memory port are used in the
// next cycle, and the result is then loaded into the output register in
// the load state, which raises o_rsp.valid; a new request can be taken
// only after that load, once the sequencer is back in the idle state. The
// sequencer has three states: take the request, execute, load the result.
// A finished result waits in the output register while the next request is
// taken and executed; if the receiver holds o_rsp.ready low, the sequencer
// waits before loading, and i_req.ready stays low until it can proceed.
// Reset (synchronous, active low) empties every stack and drops o_rsp.valid;
// memory contents are not cleared and need no clearing pass.
module partitioned_multi_stack import pms_pkg::*; #(
    parameter int STACK_COUNT = 2,
    parameter int SEG_DEPTH   = 8,
    parameter int DATA_WIDTH  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pms_req_if.sink   i_req,
    pms_rsp_if.source o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pms_dp #(
        .STACK_COUNT (STACK_COUNT),
        .SEG_DEPTH   (SEG_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_req.func),
        .i_stack_id   (i_req.stack_id),
        .i_push_value (i_req.push_value),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_pop_data   (o_rsp.pop_data),
        .o_status     (o_rsp.status)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while another is in flight");

    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.pop_data == '0))
        else $error("error response carries data");

    a_load_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(!i_req.ready))
        else $error("response loaded while sequencer idle");

endmodule
